// ----- rtl/htlp_pkg.sv -----
// types and constants shared by the linear probe hash table
// no dependencies
package htlp_pkg;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value_out;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_GET = 2'd1,
      OP_DEL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_LIVE = 2'd1,
      SLOT_TOMB = 2'd2
   } slot_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_HASH,
      FE_MOD,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_READ,
      BE_CHECK,
      BE_DONE
   } be_state_type;

   localparam logic [63:0] HASH_SEED = 64'h013811c9dc5beafa;

endpackage

// ----- rtl/hash_table_linear_probe.sv -----
// channel | ports                              | direction
// request | req_push req_full req_data         | in
// result  | rsp_empty rsp_pop rsp_data         | out
// config  | csr_we csr_wdata                   | in
// the front end takes an item through an idle state, one hash state per key
// byte up to the terminator, a 64-step restoring modulo and a handoff state
// the back end reads, then checks, each probed slot, then applies the operation, and waits while a result is held
// a reset clears all TABLE_DEPTH slot states in turn; no item is taken meanwhile
// the request queue holds two items, so both ends stall independently
// depends on htlp_pkg, htlp_front, htlp_fifo, htlp_back
module hash_table_linear_probe #(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  htlp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output htlp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [8:0]        csr_wdata
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   logic [8:0] size_reg_ff;
   logic [IDX_W:0] size;
   logic fv, fr, bv, br, fe_full, clr;
   htlp_pkg::req_type freq, breq;
   logic [IDX_W-1:0] fhome, bhome;

   always_ff @(posedge clock) begin
      if (reset) size_reg_ff <= 9'd256;
      else if (csr_we) size_reg_ff <= csr_wdata;
   end

   always_comb begin
      if ({{(IDX_W+1){1'b0}}, size_reg_ff} < (IDX_W+10)'(2)) size = (IDX_W+1)'(2);
      else if ({{(IDX_W+1){1'b0}}, size_reg_ff} > (IDX_W+10)'(TABLE_DEPTH))
         size = (IDX_W+1)'(TABLE_DEPTH);
      else size = (IDX_W+1)'(size_reg_ff);
   end

   assign req_full = fe_full || clr;

   htlp_front #(.IDX_W(IDX_W), .KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req_push(req_push && !clr), .req_full(fe_full),
      .req_data, .size, .job_valid(fv), .job_ready(fr), .job_req(freq), .job_home(fhome));

   htlp_fifo #(.IDX_W(IDX_W)) u_fifo (
      .clock, .reset, .in_valid(fv), .in_ready(fr), .in_req(freq), .in_home(fhome),
      .out_valid(bv), .out_ready(br), .out_req(breq), .out_home(bhome));

   htlp_back #(.IDX_W(IDX_W), .DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .size, .job_valid(bv), .job_ready(br), .job_req(breq),
      .job_home(bhome), .rsp_empty, .rsp_pop, .rsp_data, .clear_busy(clr));
endmodule

// ----- rtl/htlp_front.sv -----
// front end: accepts an item, normalizes the key, hashes it a byte a cycle
// and reduces the hash modulo the size by restoring division; depends on htlp_pkg
module htlp_front #(
   parameter int IDX_W = 8,
   parameter int KEY_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  htlp_pkg::req_type     req_data,
   input  logic [IDX_W:0]        size,
   output logic                  job_valid,
   input  logic                  job_ready,
   output htlp_pkg::req_type     job_req,
   output logic [IDX_W-1:0]      job_home
);
   htlp_pkg::fe_state_type state_ff, state_in;
   htlp_pkg::req_type req_ff, req_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [63:0] raw_ff, raw_in, nkey_ff, nkey_in;
   logic [7:0] b;
   logic [64:0] trial;

   always_comb begin
      b = raw_ff[cnt_ff[2:0]*8 +: 8];
      trial = {rem_ff, hash_ff[63]} - {{(64-IDX_W){1'b0}}, size};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htlp_pkg::FE_IDLE: if (req_push) state_in = htlp_pkg::FE_HASH;
         htlp_pkg::FE_HASH:
            if (b == 8'd0 || cnt_ff == 7'(KEY_BYTES - 1)) state_in = htlp_pkg::FE_MOD;
         htlp_pkg::FE_MOD: if (cnt_ff == 7'd63) state_in = htlp_pkg::FE_PUSH;
         htlp_pkg::FE_PUSH: if (job_ready) state_in = htlp_pkg::FE_IDLE;
         default: state_in = htlp_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      hash_in = hash_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         htlp_pkg::FE_IDLE: begin
            req_in = req_data;
            req_in.key = 64'd0;
            hash_in = htlp_pkg::HASH_SEED;
            cnt_in = 7'd0;
         end
         htlp_pkg::FE_HASH: begin
            if (b != 8'd0) begin
               hash_in = ((hash_ff ^ {56'd0, b}) << 8) + {56'd0, b};
            end
            cnt_in = cnt_ff + 7'd1;
            if (state_in == htlp_pkg::FE_MOD) begin
               cnt_in = 7'd0;
               rem_in = 64'd0;
            end
         end
         htlp_pkg::FE_MOD: begin
            if (!trial[64]) rem_in = trial[63:0];
            else rem_in = {rem_ff[62:0], hash_ff[63]};
            hash_in = {hash_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
         end
         default: ;
      endcase
   end

   // key bytes kept separately while hashing
   always_comb begin
      raw_in = raw_ff;
      nkey_in = nkey_ff;
      if (state_ff == htlp_pkg::FE_IDLE) begin
         raw_in = req_data.key;
         nkey_in = 64'd0;
      end else if (state_ff == htlp_pkg::FE_HASH && raw_ff[cnt_ff[2:0]*8 +: 8] != 8'd0)
         nkey_in[cnt_ff[2:0]*8 +: 8] = raw_ff[cnt_ff[2:0]*8 +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= htlp_pkg::FE_IDLE;
      else state_ff <= state_in;
      req_ff <= req_in;
      hash_ff <= hash_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      raw_ff <= raw_in;
      nkey_ff <= nkey_in;
   end

   assign req_full = (state_ff != htlp_pkg::FE_IDLE);
   assign job_valid = (state_ff == htlp_pkg::FE_PUSH);
   always_comb begin
      job_req = req_ff;
      job_req.key = nkey_ff;
   end
   assign job_home = rem_ff[IDX_W-1:0];
endmodule

// ----- rtl/htlp_fifo.sv -----
// short queue of classified items between front and back end
// depends on htlp_pkg
module htlp_fifo #(
   parameter int IDX_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  htlp_pkg::req_type in_req,
   input  logic [IDX_W-1:0]  in_home,
   output logic              out_valid,
   input  logic              out_ready,
   output htlp_pkg::req_type out_req,
   output logic [IDX_W-1:0]  out_home
);
   htlp_pkg::req_type req_ff [2];
   logic [IDX_W-1:0] home_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_req = req_ff[rp_ff];
   assign out_home = home_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) begin
         req_ff[wp_ff] <= in_req;
         home_ff[wp_ff] <= in_home;
      end
   end

`ifndef ASSERT_OFF
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("bad count");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("item lost");
`endif
endmodule

// ----- rtl/htlp_back.sv -----
// back end: probes the slot memories and applies put, get or delete
// depends on htlp_pkg
module htlp_back #(
   parameter int IDX_W = 8,
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W:0]    size,
   input  logic              job_valid,
   output logic              job_ready,
   input  htlp_pkg::req_type job_req,
   input  logic [IDX_W-1:0]  job_home,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output htlp_pkg::rsp_type rsp_data,
   output logic              clear_busy
);
   localparam int CNT_W = IDX_W + 1;
   htlp_pkg::be_state_type state_ff, state_in;
   logic [1:0] stat_mem [DEPTH];
   logic [63:0] key_mem [DEPTH];
   logic [63:0] val_mem [DEPTH];
   logic [1:0] st_rd_ff;
   logic [63:0] key_rd_ff, val_rd_ff;
   htlp_pkg::req_type req_ff;
   logic [IDX_W-1:0] idx_ff, tomb_ff, spot_ff;
   logic [CNT_W-1:0] steps_ff, count_ff;
   logic have_tomb_ff, have_empty_ff, hit_ff;
   logic clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic rsp_full_ff;
   htlp_pkg::rsp_type rsp_ff;
   logic stop, last;
   logic [CNT_W-1:0] nxt;

   assign last = (steps_ff + CNT_W'(1) == size);
   assign nxt = {1'b0, idx_ff} + CNT_W'(1);
   assign stop = (st_rd_ff == htlp_pkg::SLOT_EMPTY) ||
      (st_rd_ff == htlp_pkg::SLOT_LIVE && key_rd_ff == req_ff.key) || last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htlp_pkg::BE_IDLE: if (job_valid && !clr_ff) state_in = htlp_pkg::BE_READ;
         htlp_pkg::BE_READ: state_in = htlp_pkg::BE_CHECK;
         htlp_pkg::BE_CHECK: state_in = stop ? htlp_pkg::BE_DONE : htlp_pkg::BE_READ;
         htlp_pkg::BE_DONE: if (!rsp_full_ff) state_in = htlp_pkg::BE_IDLE;
         default: state_in = htlp_pkg::BE_IDLE;
      endcase
   end

   assign job_ready = (state_ff == htlp_pkg::BE_IDLE) && !clr_ff;
   assign clear_busy = clr_ff;
   assign rsp_empty = !rsp_full_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == htlp_pkg::BE_READ || state_ff == htlp_pkg::BE_IDLE) begin
         st_rd_ff <= stat_mem[idx_ff];
         key_rd_ff <= key_mem[idx_ff];
         val_rd_ff <= val_mem[idx_ff];
      end
      if (clr_ff) stat_mem[clr_idx_ff] <= htlp_pkg::SLOT_EMPTY;
      case (state_ff)
         htlp_pkg::BE_IDLE: begin
            req_ff <= job_req;
            idx_ff <= job_home;
            steps_ff <= '0;
            have_tomb_ff <= 1'b0;
            have_empty_ff <= 1'b0;
            hit_ff <= 1'b0;
         end
         htlp_pkg::BE_CHECK: begin
            if (st_rd_ff == htlp_pkg::SLOT_EMPTY) begin
               have_empty_ff <= 1'b1;
               spot_ff <= idx_ff;
            end else if (st_rd_ff == htlp_pkg::SLOT_LIVE) begin
               if (key_rd_ff == req_ff.key) begin
                  hit_ff <= 1'b1;
                  spot_ff <= idx_ff;
               end
            end else if (!have_tomb_ff) begin
               have_tomb_ff <= 1'b1;
               tomb_ff <= idx_ff;
            end
            if (!stop) begin
               steps_ff <= steps_ff + CNT_W'(1);
               idx_ff <= (nxt == size) ? '0 : nxt[IDX_W-1:0];
            end
         end
         htlp_pkg::BE_DONE: if (!rsp_full_ff) begin
            rsp_ff.value_out <= 64'd0;
            rsp_ff.status <= htlp_pkg::ST_NOT_FOUND;
            case (req_ff.operation)
               htlp_pkg::OP_PUT: begin
                  if (hit_ff) begin
                     val_mem[spot_ff] <= req_ff.value;
                     rsp_ff.status <= htlp_pkg::ST_OK;
                  end else if (have_tomb_ff || have_empty_ff) begin
                     stat_mem[have_tomb_ff ? tomb_ff : spot_ff] <= htlp_pkg::SLOT_LIVE;
                     key_mem[have_tomb_ff ? tomb_ff : spot_ff] <= req_ff.key;
                     val_mem[have_tomb_ff ? tomb_ff : spot_ff] <= req_ff.value;
                     rsp_ff.status <= htlp_pkg::ST_OK;
                  end else rsp_ff.status <= htlp_pkg::ST_FULL;
               end
               htlp_pkg::OP_GET: if (hit_ff) begin
                  rsp_ff.value_out <= val_rd_ff;
                  rsp_ff.status <= htlp_pkg::ST_OK;
               end
               htlp_pkg::OP_DEL: if (hit_ff) begin
                  stat_mem[spot_ff] <= htlp_pkg::SLOT_TOMB;
                  rsp_ff.status <= htlp_pkg::ST_OK;
               end
               default: ;
            endcase
            rsp_ff.entry_count <= 9'(count_ff + CNT_W'(
               (req_ff.operation == htlp_pkg::OP_PUT && !hit_ff &&
                (have_tomb_ff || have_empty_ff)) ? 1 : 0) - CNT_W'(
               (req_ff.operation == htlp_pkg::OP_DEL && hit_ff && count_ff != '0) ? 1 : 0));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htlp_pkg::BE_IDLE;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
         rsp_full_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(DEPTH - 1)) clr_ff <= 1'b0;
         end
         if (state_ff == htlp_pkg::BE_DONE && !rsp_full_ff) begin
            rsp_full_ff <= 1'b1;
            if (req_ff.operation == htlp_pkg::OP_PUT && !hit_ff &&
                (have_tomb_ff || have_empty_ff)) count_ff <= count_ff + CNT_W'(1);
            else if (req_ff.operation == htlp_pkg::OP_DEL && hit_ff && count_ff != '0)
               count_ff <= count_ff - CNT_W'(1);
         end else if (rsp_pop && rsp_full_ff) rsp_full_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_no_job_clr: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> state_ff == htlp_pkg::BE_IDLE) else $error("job during clear");
   a_probe_lim: assert property (@(posedge clock) disable iff (reset)
      state_ff == htlp_pkg::BE_CHECK |-> steps_ff < size) else $error("probe overrun");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == htlp_pkg::BE_READ |-> {1'b0, idx_ff} < size) else $error("index out");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("count overflow");
`endif
endmodule

// ----- bench/tb_hash_table_linear_probe.sv -----
`timescale 1ns / 1ps
// self-checking bench for the linear probe hash table: put, get and delete
// items checked against an in-bench table model; depends on htlp_pkg and hash_table_linear_probe
module tb_hash_table_linear_probe;

   localparam int DEPTH = 256;
   localparam int RAND_ITEMS = 1500;
   localparam longint CYCLE_LIMIT = 10000000;
   localparam int TAIL_GAP = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   htlp_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   htlp_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;

   hash_table_linear_probe u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // table model
   logic [8:0] size_reg;
   htlp_pkg::slot_type slot_state[DEPTH];
   logic [63:0] slot_key[DEPTH];
   logic [63:0] slot_val[DEPTH];
   logic [8:0] live_count;
   htlp_pkg::rsp_type pending_rsp[$];
   int errors = 0;
   int rsp_seen = 0;
   int full_seen = 0;
   int miss_seen = 0;
   longint cycles = 0;
   bit quiet = 1'b0;
   logic [63:0] key_pool[16];

   function automatic logic [63:0] trim_key(logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (k[8*i +: 8] == 8'd0) break;
         r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
   endfunction

   function automatic logic [63:0] key_digest(logic [63:0] k);
      logic [63:0] h;
      logic [63:0] b;
      h = htlp_pkg::HASH_SEED;
      for (int i = 0; i < 8; i++) begin
         b = {56'd0, k[8*i +: 8]};
         if (b == 64'd0) break;
         h = ((h ^ b) << 8) + b;
      end
      return h;
   endfunction

   function automatic htlp_pkg::rsp_type table_apply(htlp_pkg::req_type rq);
      htlp_pkg::rsp_type r;
      logic [63:0] k;
      int sz, home, idx, tomb, spot;
      bit have_tomb, have_empty, hit;
      k = trim_key(rq.key);
      sz = size_reg < 9'd2 ? 2 : (size_reg > 9'(DEPTH) ? DEPTH : int'(size_reg));
      home = int'(key_digest(k) % 64'(sz));
      have_tomb = 0; have_empty = 0; hit = 0; tomb = 0; spot = 0;
      for (int i = 0; i < sz; i++) begin
         idx = (home + i) % sz;
         if (slot_state[idx] == htlp_pkg::SLOT_EMPTY) begin
            have_empty = 1; spot = idx; break;
         end
         if (slot_state[idx] == htlp_pkg::SLOT_TOMB) begin
            if (!have_tomb) begin
               have_tomb = 1; tomb = idx;
            end
            continue;
         end
         if (slot_key[idx] == k) begin
            hit = 1; spot = idx; break;
         end
      end
      r.status = htlp_pkg::ST_NOT_FOUND;
      r.value_out = '0;
      case (htlp_pkg::op_type'(rq.operation))
         htlp_pkg::OP_PUT: begin
            if (hit) begin
               slot_val[spot] = rq.value;
               r.status = htlp_pkg::ST_OK;
            end else if (have_tomb || have_empty) begin
               idx = have_tomb ? tomb : spot;
               slot_state[idx] = htlp_pkg::SLOT_LIVE;
               slot_key[idx] = k;
               slot_val[idx] = rq.value;
               live_count++;
               r.status = htlp_pkg::ST_OK;
            end else begin
               r.status = htlp_pkg::ST_FULL;
            end
         end
         htlp_pkg::OP_GET: begin
            if (hit) begin
               r.value_out = slot_val[spot];
               r.status = htlp_pkg::ST_OK;
            end
         end
         htlp_pkg::OP_DEL: begin
            if (hit) begin
               slot_state[spot] = htlp_pkg::SLOT_TOMB;
               if (live_count > 9'd0) live_count--;
               r.status = htlp_pkg::ST_OK;
            end
         end
         default: ;
      endcase
      r.entry_count = live_count;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
   endtask

   // result side: random pop bursts, checks at the rising edge
   always @(posedge clock) begin
      htlp_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.value_out, 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.value_out !== want.value_out)
               report_mismatch("value_out", rsp_data.value_out, want.value_out);
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(rsp_data.entry_count),
                  64'(want.entry_count));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d items outstanding", pending_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = int'($urandom_range(1, 19));
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // push stays high on return so back-to-back items need one assignment per edge
   task automatic send_item(htlp_pkg::req_type rq, bit with_gaps);
      if (with_gaps && !quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_data <= rq;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      pending_rsp.push_back(table_apply(rq));
      @(negedge clock);
   endtask

   task automatic drain_and_idle();
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (TAIL_GAP) @(negedge clock);
   endtask

   task automatic set_size(logic [8:0] sz);
      drain_and_idle();
      csr_wdata <= sz;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      size_reg = sz;
   endtask

   function automatic htlp_pkg::req_type make_item(htlp_pkg::op_type op, logic [63:0] k,
                                                   logic [63:0] v);
      htlp_pkg::req_type r;
      r.operation = op;
      r.key = k;
      r.value = v;
      return r;
   endfunction

   function automatic logic [63:0] rand_key();
      logic [63:0] k;
      int len;
      k = {$urandom, $urandom};
      len = int'($urandom_range(0, 8));
      if (len < 8) k[8*len +: 8] = 8'd0;
      return k;
   endfunction

   // directed rows; expected result typed in where obvious, else predicted
   typedef struct {
      htlp_pkg::req_type rq;
      bit typed;
      htlp_pkg::rsp_type want;
   } dir_row_type;

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      htlp_pkg::rsp_type got_model;
      htlp_pkg::req_type rq;
      int n_items, sel;
      for (int i = 0; i < DEPTH; i++) begin
         slot_state[i] = htlp_pkg::SLOT_EMPTY;
         slot_key[i] = '0;
         slot_val[i] = '0;
      end
      size_reg = 9'd256;
      live_count = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      row.typed = 1;
      row.rq = make_item(htlp_pkg::OP_GET, 64'h0000_0000_0061_6263, 64'd0);
      row.want = '{htlp_pkg::ST_NOT_FOUND, 64'd0, 9'd0}; rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      row.want = '{htlp_pkg::ST_NOT_FOUND, 64'd0, 9'd0}; rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_NONE, 64'h41, 64'hFFFF_FFFF_FFFF_FFFF);
      row.want = '{htlp_pkg::ST_NOT_FOUND, 64'd0, 9'd0}; rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_PUT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      row.want = '{htlp_pkg::ST_OK, 64'd0, 9'd1}; rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_GET, 64'hFFFF_0000_0000_0000, 64'd0);
      row.want = '{htlp_pkg::ST_OK, 64'hFFFF_FFFF_FFFF_FFFF, 9'd1}; rows.push_back(row);
      row.typed = 0;
      row.rq = make_item(htlp_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_PUT, 64'h00AB_00FF_FFFF_FFFF, 64'h5678);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_PUT, 64'h0000_0000_00FF_FFFF, 64'h0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_GET, 64'h1100_0000_00FF_FFFF, 64'd0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_PUT, 64'h0102_0304_0506_0708, 64'hAAAA_5555_AAAA_5555);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_DEL, 64'h0102_0304_0506_0708, 64'd0);
      rows.push_back(row);
      row.rq = make_item(htlp_pkg::OP_GET, 64'h00FF_FFFF_FFFF_FFFF, 64'd0);
      rows.push_back(row);

      foreach (rows[i]) begin
         send_item(rows[i].rq, 0);
         if (rows[i].typed) begin
            got_model = pending_rsp[pending_rsp.size()-1];
            if (got_model.status != rows[i].want.status)
               report_mismatch("table row status", 64'(got_model.status),
                  64'(rows[i].want.status));
            if (got_model.value_out != rows[i].want.value_out)
               report_mismatch("table row value", got_model.value_out,
                  rows[i].want.value_out);
            if (got_model.entry_count != rows[i].want.entry_count)
               report_mismatch("table row count", 64'(got_model.entry_count),
                  64'(rows[i].want.entry_count));
         end
      end

      // full table and out-of-range sizes
      set_size(9'd0);
      for (int i = 0; i < 5; i++)
         send_item(make_item(htlp_pkg::OP_PUT, 64'h30 + 64'(i), 64'(i)), 0);
      send_item(make_item(htlp_pkg::OP_DEL, 64'h30, 64'd0), 0);
      send_item(make_item(htlp_pkg::OP_PUT, 64'h39, 64'd9), 0);
      send_item(make_item(htlp_pkg::OP_GET, 64'h39, 64'd0), 0);
      set_size(9'd511);
      send_item(make_item(htlp_pkg::OP_GET, 64'h31, 64'd0), 0);

      // random phases over several sizes, a small key pool for hits
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_size(9'd2);
            1: set_size(9'd256);
            2: set_size(9'd3);
            3: set_size(9'd1);
            4: set_size(9'd300);
            default: set_size(9'd7 + 9'($urandom_range(0, 40)));
         endcase
         foreach (key_pool[i]) key_pool[i] = rand_key();
         n_items = RAND_ITEMS / 6;
         if (ph == 5) quiet = 1;
         for (int i = 0; i < n_items; i++) begin
            sel = int'($urandom_range(0, 9));
            rq.key = sel < 8 ? key_pool[$urandom_range(0, 15)] : rand_key();
            rq.value = {$urandom, $urandom};
            sel = int'($urandom_range(0, 19));
            rq.operation = sel < 9 ? htlp_pkg::OP_PUT : sel < 15 ? htlp_pkg::OP_GET :
               sel < 19 ? htlp_pkg::OP_DEL : htlp_pkg::OP_NONE;
            send_item(rq, 1);
            if (pending_rsp[pending_rsp.size()-1].status == htlp_pkg::ST_FULL) full_seen++;
            if (pending_rsp[pending_rsp.size()-1].status == htlp_pkg::ST_NOT_FOUND)
               miss_seen++;
            if (ph == 2 && i == 50) begin
               req_push <= 1'b0;
               while (pending_rsp.size() != 0) @(negedge clock);
            end
         end
      end

      drain_and_idle();
      $display("checked %0d results over six table sizes plus directed rows", rsp_seen);
      $display("full-table results %0d, not-found results %0d", full_seen, miss_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
